[rtl/plir_pkg.sv]
// ----------------------------------------------------------------------------
// plir_pkg
// Shared types and constants for the positional list block.
// ----------------------------------------------------------------------------
package plir_pkg;

    localparam int DEPTH    = 32;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 6;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MARK   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                done;
    } t_entry;

    // command broadcast to every cell; strobes only for accepted, legal beats
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             mark;
        logic [POS_W-1:0] pos;
        t_entry           data;
    } t_cmd;

endpackage

[rtl/plir_cell.sv]
// ----------------------------------------------------------------------------
// plir_cell
// One list slot. Shifts up from the lower neighbor on insert, down from the
// upper neighbor on remove, and drives its entry when the read hits it.
// ----------------------------------------------------------------------------
module plir_cell (
    input  logic                   i_clk,
    input  logic [plir_pkg::IDX_W-1:0] i_idx,
    input  plir_pkg::t_cmd         i_cmd,
    input  plir_pkg::t_entry       i_below,
    input  plir_pkg::t_entry       i_above,
    output plir_pkg::t_entry       o_entry,
    output plir_pkg::t_entry       o_rd
);
    import plir_pkg::*;

    t_entry           r_entry;
    t_entry           n_entry;
    logic [POS_W-1:0] w_idx;
    logic             w_hit;
    logic             w_above_pos;

    assign w_idx       = POS_W'(i_idx);
    assign w_hit       = (w_idx == i_cmd.pos);
    assign w_above_pos = (w_idx > i_cmd.pos);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (w_above_pos) begin
                n_entry = i_below;
            end else if (w_hit) begin
                n_entry = i_cmd.data;
            end
        end else if (i_cmd.rem) begin
            if (w_hit || w_above_pos) begin
                n_entry = i_above;
            end
        end else if (i_cmd.mark && w_hit) begin
            n_entry.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_rd    = w_hit ? r_entry : '0;

endmodule

[rtl/positional_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered list of task handles with insert/remove at a position.
// ----------------------------------------------------------------------------
// Holds up to 32 entries (16-bit handle plus done flag) in a row of slot
// cells. Each input beat is one operation: insert, remove, mark done or read
// at a position; every beat returns one result beat with status and the
// entry count after the operation. All slots shift together, so a new
// beat is taken each cycle while the output register is empty or being
// drained. Slots at or above the count hold stale data and are never
// read.
module positional_list_insert_remove (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // opcode[1:0], position[7:2], task_handle[23:8], done_in[24], zero fill
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], entry_count[7:2], read_handle[23:8], read_done[24], zero fill
    output logic [31:0] o_m_tdata
);
    import plir_pkg::*;

    t_op                 w_op;
    logic [POS_W-1:0]    w_pos;
    t_entry              w_new;
    logic                w_accept;
    t_status             w_status;
    t_cmd                w_cmd;
    t_entry              w_rd;
    logic [CNT_W-1:0]    n_count;

    logic [CNT_W-1:0]    r_count;
    logic                r_valid;
    t_status             r_status;
    logic [CNT_W-1:0]    r_out_count;
    t_entry              r_rd;

    t_entry              w_entry [DEPTH];
    t_entry              w_below [DEPTH];
    t_entry              w_above [DEPTH];
    t_entry              w_cell_rd [DEPTH];

    assign w_op       = t_op'(i_s_tdata[1:0]);
    assign w_pos      = i_s_tdata[7:2];
    assign w_new      = '{handle: i_s_tdata[23:8], done: i_s_tdata[24]};
    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        w_status = ST_OK;
        if (w_op == OP_INSERT) begin
            priority if (w_pos > r_count) begin
                w_status = ST_BAD_POS;
            end else if (r_count == CNT_W'(DEPTH)) begin
                w_status = ST_FULL;
            end
        end else begin
            priority if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (w_pos >= r_count) begin
                w_status = ST_BAD_POS;
            end
        end
    end

    always_comb begin
        w_cmd      = '0;
        w_cmd.pos  = w_pos;
        w_cmd.data = w_new;
        if (w_accept && w_status == ST_OK) begin
            w_cmd.ins  = (w_op == OP_INSERT);
            w_cmd.rem  = (w_op == OP_REMOVE);
            w_cmd.mark = (w_op == OP_MARK);
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_below[g] = '0;
        end else begin : g_mid_lo
            assign w_below[g] = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_above[g] = '0;
        end else begin : g_mid_hi
            assign w_above[g] = w_entry[g+1];
        end

        plir_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_below (w_below[g]),
            .i_above (w_above[g]),
            .o_entry (w_entry[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    // at most one cell matches the position, so OR-combine the read taps
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd = w_rd | w_cell_rd[k];
        end
        if (!(w_op == OP_READ && w_status == ST_OK)) begin
            w_rd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_out_count <= n_count;
            r_rd        <= w_rd;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'd0, r_rd.done, r_rd.handle, r_out_count, r_status};

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_EMPTY |-> r_out_count == '0)
        else $error("empty status with nonzero count");

    a_rd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_OK |-> r_rd == '0)
        else $error("read data on a failed operation");

endmodule
